@@ hw/rtl/rlm_pkg.sv @@
// ----------------------------------------------------------------------------
// rlm_pkg
// Shared types and constants of the rms level meter: controller states,
// the command and status bundles, and the register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rlm_pkg;

  localparam int unsigned SumW    = 42;
  localparam int unsigned CountW  = 13;
  localparam int unsigned LevelW  = 15;
  localparam int unsigned ScaledW = 16;
  localparam int unsigned WeightW = 8;
  localparam int unsigned CfgW    = 15;
  localparam int unsigned StepW   = 6;

  localparam logic [StepW-1:0] DivSteps   = 6'd42;
  localparam logic [StepW-1:0] SqrtSteps  = 6'd15;
  localparam logic [StepW-1:0] ScaleSteps = 6'd15;

  localparam logic [WeightW-1:0] WeightReset    = 8'd18;
  localparam logic [CfgW-1:0]    FullScaleReset = 15'd5571;
  localparam logic [LevelW-1:0]  RmsMax         = 15'd16384;
  localparam logic [ScaledW-1:0] ScaledMax      = 16'd32768;

  typedef enum logic [0:0] {
    RegSmoothingWeight = 1'b0,
    RegFullScaleLevel  = 1'b1
  } reg_index_e;

  typedef enum logic [3:0] {
    StIdle,
    StAccLeft,
    StAccRight,
    StDivInit,
    StDiv,
    StSqrtInit,
    StSqrt,
    StSmoothMul,
    StSmoothAdd,
    StScaleInit,
    StScale,
    StEmit
  } state_e;

  typedef struct packed {
    logic capture;
    logic acc_left;
    logic acc_right;
    logic div_init;
    logic div_step;
    logic sqrt_init;
    logic sqrt_step;
    logic smooth_mul;
    logic smooth_add;
    logic scale_init;
    logic scale_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic buf_end;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

@@ hw/rtl/rlm_ctrl.sv @@
// ----------------------------------------------------------------------------
// rlm_ctrl
// Sequencer of the rms level meter: walks each frame through accumulation
// and, at buffer end, through divide, square root, smoothing and rescale.
// ----------------------------------------------------------------------------
`default_nettype none

module rlm_ctrl
  import rlm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  state_e           state_q, state_d;
  logic [StepW-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) begin
          state_d = StAccLeft;
        end
      end
      StAccLeft: begin
        cmd_o.acc_left = 1'b1;
        state_d        = StAccRight;
      end
      StAccRight: begin
        cmd_o.acc_right = 1'b1;
        state_d         = status_i.buf_end ? StDivInit : StIdle;
      end
      StDivInit: begin
        cmd_o.div_init = 1'b1;
        cnt_d          = DivSteps - 6'd1;
        state_d        = StDiv;
      end
      StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = StSqrtInit;
        end
      end
      StSqrtInit: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = SqrtSteps - 6'd1;
        state_d         = StSqrt;
      end
      StSqrt: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = StSmoothMul;
        end
      end
      StSmoothMul: begin
        cmd_o.smooth_mul = 1'b1;
        state_d          = StSmoothAdd;
      end
      StSmoothAdd: begin
        cmd_o.smooth_add = 1'b1;
        state_d          = StScaleInit;
      end
      StScaleInit: begin
        cmd_o.scale_init = 1'b1;
        cnt_d            = ScaleSteps - 6'd1;
        state_d          = StScale;
      end
      StScale: begin
        cmd_o.scale_step = 1'b1;
        cnt_d            = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        cmd_o.emit = status_i.out_free;
        if (status_i.out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/rlm_dp.sv @@
// ----------------------------------------------------------------------------
// rlm_dp
// Datapath of the rms level meter: square accumulator, shift-subtract
// divider, digit square root, smoothing multiply and rescale divider,
// with the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rlm_dp
  import rlm_pkg::*;
#(
  parameter int unsigned MaxFrames = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire cmd_t                cmd_i,
  output status_t                  status_o,
  input  wire logic signed [15:0]  left_sample_i,
  input  wire logic signed [15:0]  right_sample_i,
  input  wire logic                last_frame_i,
  input  wire logic [WeightW-1:0]  weight_i,
  input  wire logic [CfgW-1:0]     full_scale_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic [LevelW-1:0]        rms_level_o,
  output logic [LevelW-1:0]        smoothed_level_o,
  output logic [ScaledW-1:0]       scaled_level_o
);

  // frame capture and accumulation
  logic signed [14:0] lsmp_q, rsmp_q;
  logic               last_q;
  logic [SumW-1:0]    sum_q;
  logic [CountW-1:0]  count_q;
  logic signed [15:0] lhalf, rhalf;
  logic signed [14:0] mul_a;
  logic signed [29:0] sq;

  // divider
  logic [SumW-1:0]   divd_q;
  logic [13:0]       drem_q, dvsr_q;
  logic [14:0]       dtrial;
  logic              dge;

  // square root
  logic [29:0]       sop_q;
  logic [16:0]       srem_q;
  logic [14:0]       root_q;
  logic [18:0]       scur, strial;
  logic              sge;

  // smoothing
  logic [LevelW-1:0]  rms_c, rms_q, smoothed_q;
  logic signed [15:0] diff;
  logic signed [24:0] prod, prod_q;
  logic signed [16:0] step, smooth_sum;

  // rescale
  logic [CfgW-1:0]   fs_eff, fsr_q, srm_q;
  logic [14:0]       quo_q;
  logic              clamp_q;
  logic [15:0]       ctrial;
  logic              cge;

  logic              out_valid_q;

  assign lhalf = left_sample_i >>> 1;
  assign rhalf = right_sample_i >>> 1;
  assign mul_a = cmd_i.acc_left ? lsmp_q : rsmp_q;
  assign sq    = mul_a * mul_a;

  assign dtrial = {drem_q, divd_q[SumW-1]};
  assign dge    = dtrial >= {1'b0, dvsr_q};

  assign scur   = {srem_q, sop_q[29:28]};
  assign strial = {2'b00, root_q, 2'b01};
  assign sge    = scur >= strial;

  assign rms_c      = (root_q > RmsMax) ? RmsMax : root_q;
  assign diff       = $signed({1'b0, rms_c}) - $signed({1'b0, smoothed_q});
  assign prod       = diff * $signed({1'b0, weight_i});
  assign step       = prod_q[24:8];
  assign smooth_sum = $signed({2'b00, smoothed_q}) + step;

  assign fs_eff = (full_scale_i == '0) ? 15'd1 : full_scale_i;
  assign ctrial = {srm_q, 1'b0};
  assign cge    = ctrial >= {1'b0, fsr_q};

  assign status_o.buf_end  = last_q || (count_q >= CountW'(MaxFrames));
  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      smoothed_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.acc_left || cmd_i.acc_right) begin
        sum_q <= sum_q + SumW'(sq[28:0]);
      end else if (cmd_i.div_init) begin
        sum_q <= '0;
      end
      if (cmd_i.acc_left) begin
        count_q <= count_q + 13'd1;
      end else if (cmd_i.div_init) begin
        count_q <= '0;
      end
      if (cmd_i.smooth_add) begin
        smoothed_q <= smooth_sum[14:0];
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lsmp_q <= lhalf[14:0];
      rsmp_q <= rhalf[14:0];
      last_q <= last_frame_i;
    end
    if (cmd_i.div_init) begin
      divd_q <= sum_q;
      drem_q <= '0;
      dvsr_q <= {count_q, 1'b0};
    end else if (cmd_i.div_step) begin
      drem_q <= dge ? 14'(dtrial - {1'b0, dvsr_q}) : dtrial[13:0];
      divd_q <= {divd_q[SumW-2:0], dge};
    end
    if (cmd_i.sqrt_init) begin
      sop_q  <= divd_q[29:0];
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      srem_q <= sge ? 17'(scur - strial) : scur[16:0];
      root_q <= {root_q[13:0], sge};
      sop_q  <= {sop_q[27:0], 2'b00};
    end
    if (cmd_i.smooth_mul) begin
      prod_q <= prod;
      rms_q  <= rms_c;
    end
    if (cmd_i.scale_init) begin
      clamp_q <= smoothed_q >= fs_eff;
      srm_q   <= smoothed_q;
      fsr_q   <= fs_eff;
      quo_q   <= '0;
    end else if (cmd_i.scale_step) begin
      srm_q <= cge ? 15'(ctrial - {1'b0, fsr_q}) : ctrial[14:0];
      quo_q <= {quo_q[13:0], cge};
    end
    if (cmd_i.emit) begin
      rms_level_o      <= rms_q;
      smoothed_level_o <= smoothed_q;
      scaled_level_o   <= clamp_q ? ScaledMax : {1'b0, quo_q};
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/rms_level_meter.sv @@
// ----------------------------------------------------------------------------
// rms_level_meter
// RMS level meter with exponential smoothing over buffers of stereo frames.
//
// Input channel: one stereo frame of Q1.15 samples per item, with a flag
// on the last frame of a buffer. Output channel: one item per ended buffer
// carrying the rms, smoothed and scaled levels. Both use valid/ready.
// Each frame is captured, then one shared multiplier squares the
// left and then the right halved sample into the accumulator.
// A buffer ends on the flagged frame or at MaxFrames frames. The end of a
// buffer then runs the 42-step shift-subtract divider, the 15-step square
// root, the smoothing multiply and add, and the 15-step rescale divider
// before the result is loaded into the output register.
// The output register holds a result while the receiver stalls; new
// frames are still accepted, and only the next buffer end waits for it.
// Reset clears the accumulator, frame count and smoothed level, and loads
// smoothing_weight = 18 and full_scale_level = 5571.
// Registers are written through cfg_we_i / cfg_index_i / cfg_data_i.
// ----------------------------------------------------------------------------
`default_nettype none

module rms_level_meter
  import rlm_pkg::*;
#(
  parameter int unsigned MaxFrames = 4096
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] left_sample_i,
  input  wire logic signed [15:0] right_sample_i,
  input  wire logic               last_frame_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [LevelW-1:0]       rms_level_o,
  output logic [LevelW-1:0]       smoothed_level_o,
  output logic [ScaledW-1:0]      scaled_level_o
);

  logic [WeightW-1:0] weight_q;
  logic [CfgW-1:0]    full_scale_q;
  cmd_t               cmd;
  status_t            status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q     <= WeightReset;
      full_scale_q <= FullScaleReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSmoothingWeight: weight_q     <= cfg_data_i[WeightW-1:0];
        RegFullScaleLevel:  full_scale_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  rlm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rlm_dp #(
    .MaxFrames (MaxFrames)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .left_sample_i    (left_sample_i),
    .right_sample_i   (right_sample_i),
    .last_frame_i     (last_frame_i),
    .weight_i         (weight_q),
    .full_scale_i     (full_scale_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .rms_level_o      (rms_level_o),
    .smoothed_level_o (smoothed_level_o),
    .scaled_level_o   (scaled_level_o)
  );

endmodule

`default_nettype wire
